### src/fws_pkg.sv
`timescale 1ns / 1ps
package fws_pkg;

	localparam int NUM_TAPS     = 16;
	localparam int SAMPLE_WIDTH = 16;
	localparam int COEF_WIDTH   = 16;
	localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int ACC_WIDTH    = 40;
	localparam int IDX_W        = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
	localparam int CNT_W        = $clog2(NUM_TAPS + 1);
	localparam int TC_WIDTH     = 5;
	localparam int OP_WIDTH     = 3;
	localparam int CIDX_WIDTH   = 4;

	localparam logic [TC_WIDTH-1:0] TC_RESET = TC_WIDTH'(16);

	localparam logic [OP_WIDTH-1:0] OP_SAMPLE  = 3'd0;
	localparam logic [OP_WIDTH-1:0] OP_FILL    = 3'd1;
	localparam logic [OP_WIDTH-1:0] OP_SAVE    = 3'd2;
	localparam logic [OP_WIDTH-1:0] OP_RESTORE = 3'd3;
	localparam logic [OP_WIDTH-1:0] OP_COEF    = 3'd4;

	typedef logic signed [SAMPLE_WIDTH-1:0] smp_t;
	typedef logic signed [COEF_WIDTH-1:0]   coef_t;
	typedef logic signed [PROD_WIDTH-1:0]   prod_t;
	typedef logic signed [ACC_WIDTH-1:0]    acc_t;

	// per-cell strobes, mutually exclusive except rot_d/rot_c
	typedef struct packed {
		logic rot_d;
		logic rot_c;
		logic wr_d;
		logic save;
		logic restore;
		logic wr_c;
	} fws_cell_ctl_t;

endpackage

### src/fir_filter_with_snapshot.sv
`timescale 1ns / 1ps
// Direct-form FIR filter with delay-line snapshot.
// Input channel (in_valid/in_ready) carries op, sample, coef_index, coef_value.
// Output channel (out_valid/out_ready) carries filtered, one transfer per
// sample op; other ops (fill, save, restore, coefficient load) give none and
// finish in the cycle of their input transfer.
// A row of NUM_TAPS cells holds delay line, saved copy and coefficient per tap.
// For a sample the delay data rotates around the first tap_count cells while
// the coefficients rotate around the full row; one shared multiplier and a
// 40-bit accumulator take one tap per cycle. The coefficient row must make a
// full turn, so every sample runs the whole row: accept, rotation through all
// cells, product drain, result handoff. A new sample is taken only once the
// previous one has been handed off.
// The output register decouples the sides: a new input transfer is taken
// while a result still waits for out_ready. If the receiver stalls, the next
// sample result waits in the accumulator until the output register frees.
// Reset clears delay line, snapshot, coefficients and positions, and sets
// tap_count to 16. Write it (cfg_we/cfg_wdata) only while idle; not enforced.
module fir_filter_with_snapshot
	import fws_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [TC_WIDTH-1:0]     cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [OP_WIDTH-1:0]     op,
	input  smp_t                    sample,
	input  logic [CIDX_WIDTH-1:0]   coef_index,
	input  coef_t                   coef_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output acc_t                    filtered
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [TC_WIDTH-1:0] tap_cnt_q;
	logic [IDX_W-1:0]    wp_q;       // live write position
	logic [IDX_W-1:0]    sp_q;       // saved position
	logic [IDX_W-1:0]    rd_pos_q;   // position of the newest sample for this run
	logic [IDX_W-1:0]    t_q;        // tap counter during rotation
	logic                out_vld_q;
	acc_t                filtered_q;

	logic [CNT_W-1:0]    n_eff;
	logic [IDX_W-1:0]    p_eff;
	logic [IDX_W-1:0]    wp_nxt;
	logic [IDX_W-1:0]    sp_eff;
	logic                xfer_in;
	logic                run;
	logic                tap_act;
	fws_cell_ctl_t       ctl [NUM_TAPS];
	smp_t                d_w [NUM_TAPS];
	coef_t               c_w [NUM_TAPS];
	smp_t                d_nbr [NUM_TAPS];
	coef_t               c_nbr [NUM_TAPS];
	acc_t                acc;

	// tap count clamp: 0 acts as 1, anything above the row length as full row
	always_comb begin
		if (tap_cnt_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(tap_cnt_q) > 32'(NUM_TAPS)) begin
			n_eff = CNT_W'(NUM_TAPS);
		end else begin
			n_eff = CNT_W'(tap_cnt_q);
		end
	end

	// stale positions fold back to zero
	assign p_eff  = (CNT_W'(wp_q) < n_eff) ? wp_q : '0;
	assign sp_eff = (CNT_W'(sp_q) < n_eff) ? sp_q : '0;
	assign wp_nxt = ((CNT_W'(p_eff) + CNT_W'(1)) >= n_eff) ? '0 : (p_eff + IDX_W'(1));

	assign in_ready = (state_q == ST_IDLE);
	assign xfer_in  = in_valid && in_ready;
	assign run      = (state_q == ST_RUN);
	assign tap_act  = run && (CNT_W'(t_q) < n_eff);

	always_comb begin
		for (int k = 0; k < NUM_TAPS; k++) begin
			ctl[k].rot_c   = run;
			ctl[k].rot_d   = tap_act && (CNT_W'(k) < n_eff);
			ctl[k].wr_d    = xfer_in &&
				((op == OP_SAMPLE && IDX_W'(k) == p_eff) ||
				 (op == OP_FILL && CNT_W'(k) < n_eff));
			ctl[k].save    = xfer_in && (op == OP_SAVE) && (CNT_W'(k) < n_eff);
			ctl[k].restore = xfer_in && (op == OP_RESTORE) && (CNT_W'(k) < n_eff);
			ctl[k].wr_c    = xfer_in && (op == OP_COEF) && (32'(coef_index) == k);
		end
	end

	// data rotates upward, wrapping from the last tap in use into cell 0;
	// coefficients rotate downward around the whole row
	always_comb begin
		for (int k = 0; k < NUM_TAPS; k++) begin
			if (k == 0) begin
				d_nbr[k] = d_w[IDX_W'(n_eff - CNT_W'(1))];
			end else begin
				d_nbr[k] = d_w[k-1];
			end
			c_nbr[k] = c_w[(k + 1) % NUM_TAPS];
		end
	end

	for (genvar g = 0; g < NUM_TAPS; g++) begin : g_cell
		fws_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[g]),
			.smp        (sample),
			.coef_value (coef_value),
			.d_nbr      (d_nbr[g]),
			.c_nbr      (c_nbr[g]),
			.d          (d_w[g]),
			.c          (c_w[g])
		);
	end

	// after t rotations cell rd_pos holds the sample t steps older than newest,
	// and cell 0 holds coefficient t
	fws_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (xfer_in),
		.en     (tap_act),
		.x      (d_w[rd_pos_q]),
		.cf     (c_w[0]),
		.acc    (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tap_cnt_q  <= TC_RESET;
			wp_q       <= '0;
			sp_q       <= '0;
			rd_pos_q   <= '0;
			t_q        <= '0;
			out_vld_q  <= 1'b0;
			filtered_q <= '0;
		end else begin
			if (cfg_we) begin
				tap_cnt_q <= cfg_wdata;
			end
			// result handoff into the output register, or plain drain of it
			if (state_q == ST_DONE && (!out_vld_q || out_ready)) begin
				out_vld_q  <= 1'b1;
				filtered_q <= acc;
			end else if (out_vld_q && out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (xfer_in) begin
						case (op)
							OP_SAMPLE: begin
								rd_pos_q <= p_eff;
								wp_q     <= wp_nxt;
								t_q      <= '0;
								state_q  <= ST_RUN;
							end
							OP_SAVE: begin
								sp_q <= p_eff;
							end
							OP_RESTORE: begin
								wp_q <= sp_eff;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RUN: begin
					t_q <= t_q + IDX_W'(1);
					if (t_q == IDX_W'(NUM_TAPS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_vld_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_vld_q;
	assign filtered  = filtered_q;

endmodule

### src/fws_cell.sv
`timescale 1ns / 1ps
module fws_cell
	import fws_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  fws_cell_ctl_t ctl,
	input  smp_t          smp,
	input  coef_t         coef_value,
	input  smp_t          d_nbr,
	input  coef_t         c_nbr,
	output smp_t          d,
	output coef_t         c
);

	smp_t  d_q;
	smp_t  s_q;
	coef_t c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= '0;
			s_q <= '0;
			c_q <= '0;
		end else begin
			if (ctl.wr_d) begin
				d_q <= smp;
			end else if (ctl.restore) begin
				d_q <= s_q;
			end else if (ctl.rot_d) begin
				d_q <= d_nbr;
			end
			if (ctl.save) begin
				s_q <= d_q;
			end
			if (ctl.wr_c) begin
				c_q <= coef_value;
			end else if (ctl.rot_c) begin
				c_q <= c_nbr;
			end
		end
	end

	assign d = d_q;
	assign c = c_q;

endmodule

### src/fws_mac.sv
`timescale 1ns / 1ps
module fws_mac
	import fws_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  clr,
	input  logic  en,
	input  smp_t  x,
	input  coef_t cf,
	output acc_t  acc
);

	prod_t prod_s1;
	logic  vld_s1;
	acc_t  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_t'(x) * prod_t'(cf);
		if (clr) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + ACC_WIDTH'(prod_s1);
		end
	end

	assign acc = acc_q;

endmodule
